>>> design/y2r_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared constants, types and helpers for the YUYV to packed RGB10 converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

   localparam int unsigned SumWidth = 24;
   localparam int unsigned ChanWidth = 10;
   localparam int unsigned FracBits = 10;

   typedef logic signed [SumWidth-1:0] sum_type;
   typedef logic [ChanWidth-1:0] chan_type;
   typedef logic [31:0] word_type;
   typedef logic [7:0] byte_type;

   localparam sum_type KRY = 24'sd4778;
   localparam sum_type KRU = 24'sd2;
   localparam sum_type KRV = 24'sd6931;
   localparam sum_type KGY = 24'sd4826;
   localparam sum_type KGU = -24'sd775;
   localparam sum_type KGV = -24'sd2670;
   localparam sum_type KBY = 24'sd4768;
   localparam sum_type KBU = 24'sd8809;
   localparam sum_type KBV = 24'sd11;

   localparam logic [8:0] LumaOffset = 9'd16;
   localparam logic [1:0] AlphaOpaque = 2'b11;
   localparam chan_type ChanMax = 10'h3FF;

   // floor shift, then clamp to 0..1023
   function automatic chan_type clamp_chan(input sum_type sum);
      sum_type shifted;
      begin
         shifted = sum >>> FracBits;
         if (sum[SumWidth-1]) begin
            clamp_chan = '0;
         end else if (shifted > sum_type'(ChanMax)) begin
            clamp_chan = ChanMax;
         end else begin
            clamp_chan = shifted[ChanWidth-1:0];
         end
      end
   endfunction

endpackage

>>> design/y2r_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r stream interfaces
// Valid/ready channels for macropixel items and packed pixel result items.
// ----------------------------------------------------------------------------
interface y2r_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] luma_first;
   logic [7:0] chroma_blue;
   logic [7:0] luma_second;
   logic [7:0] chroma_red;
   logic       last_in_line;
   logic       last_in_frame;

   modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                   last_in_line, last_in_frame, input ready);
   modport sink (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                 last_in_line, last_in_frame, output ready);
endinterface

interface y2r_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_word_first;
   logic [31:0] pixel_word_second;
   logic        line_done;
   logic        frame_done;

   modport source (output valid, pixel_word_first, pixel_word_second, line_done,
                   frame_done, input ready);
   modport sink (input valid, pixel_word_first, pixel_word_second, line_done,
                 frame_done, output ready);
endinterface

>>> design/y2r_pixel_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_pixel_conv
// One pixel: luma and shared chroma to a packed B10 G10 R10 A2 word.
// ----------------------------------------------------------------------------
module y2r_pixel_conv (
   input  y2r_pkg::byte_type luma,
   input  y2r_pkg::byte_type chroma_u,
   input  y2r_pkg::byte_type chroma_v,
   output y2r_pkg::word_type pixel_word
);
   import y2r_pkg::*;

   sum_type y_s;
   sum_type u_s;
   sum_type v_s;
   sum_type sum_r;
   sum_type sum_g;
   sum_type sum_b;

   always_comb begin
      y_s = sum_type'(signed'({1'b0, luma} - LumaOffset));
      u_s = sum_type'(signed'({~chroma_u[7], chroma_u[6:0]}));
      v_s = sum_type'(signed'({~chroma_v[7], chroma_v[6:0]}));
      sum_r = KRY * y_s + KRU * u_s + KRV * v_s;
      sum_g = KGY * y_s + KGU * u_s + KGV * v_s;
      sum_b = KBY * y_s + KBU * u_s + KBV * v_s;
      pixel_word = {clamp_chan(sum_b), clamp_chan(sum_g), clamp_chan(sum_r), AlphaOpaque};
   end

endmodule

>>> design/yuyv_to_rgb10_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_to_rgb10_packer
// YUYV 4:2:2 macropixel to two packed 10-bit RGB pixel words.
// ----------------------------------------------------------------------------
// Takes one item per clock and returns one result item per item, passed
// through an input register, the color matrix and clamp of both pixels,
// and a result register. Input is held off only while both registers
// hold items and the result is not taken; otherwise an item enters every cycle.
module yuyv_to_rgb10_packer (
   input logic        clock,
   input logic        reset,
   y2r_req_if.sink    req_chan,
   y2r_rsp_if.source  rsp_chan
);
   import y2r_pkg::*;

   logic     in_valid_ff, in_valid_in;
   byte_type y0_ff, u_ff, y1_ff, v_ff;
   logic     line_ff, frame_ff;

   logic     out_valid_ff, out_valid_in;
   word_type word0_ff, word1_ff;
   logic     line_out_ff, frame_out_ff;

   word_type word0_in, word1_in;
   logic     adv_out, adv_in;

   assign adv_out = !out_valid_ff || rsp_chan.ready;
   assign adv_in = !in_valid_ff || adv_out;
   assign req_chan.ready = adv_in;

   assign in_valid_in = adv_in ? req_chan.valid : in_valid_ff;
   assign out_valid_in = adv_out ? in_valid_ff : out_valid_ff;

   y2r_pixel_conv u_conv_first (
      .luma       (y0_ff),
      .chroma_u   (u_ff),
      .chroma_v   (v_ff),
      .pixel_word (word0_in)
   );

   y2r_pixel_conv u_conv_second (
      .luma       (y1_ff),
      .chroma_u   (u_ff),
      .chroma_v   (v_ff),
      .pixel_word (word1_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in) begin
         y0_ff <= req_chan.luma_first;
         u_ff <= req_chan.chroma_blue;
         y1_ff <= req_chan.luma_second;
         v_ff <= req_chan.chroma_red;
         line_ff <= req_chan.last_in_line;
         frame_ff <= req_chan.last_in_frame;
      end
      if (adv_out) begin
         word0_ff <= word0_in;
         word1_ff <= word1_in;
         line_out_ff <= line_ff;
         frame_out_ff <= frame_ff;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.pixel_word_first = word0_ff;
   assign rsp_chan.pixel_word_second = word1_ff;
   assign rsp_chan.line_done = line_out_ff;
   assign rsp_chan.frame_done = frame_out_ff;

endmodule
